// ===== rtl/ipga_pkg.sv =====
// Shared types, constants and helpers for the RGBA image palette/gray/alpha analyzer.
// No dependencies; every other file imports this package.
package ipga_pkg;

  localparam int PALETTE_LIMIT = 256;
  localparam int TABLE_DEPTH   = PALETTE_LIMIT + 1;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W         = 32;
  localparam int CH_W          = 8;
  localparam int CLASS_W       = 3;

  localparam logic [CLASS_W-1:0] CLASS_1BPP   = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_2BPP   = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_4BPP   = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_8BPP   = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_NO_PAL = 3'd4;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;

  // Word travelling down the row of cells.
  typedef struct packed {
    logic             vld;
    logic             found;
    logic             last;
    logic [KEY_W-1:0] key;
  } tok_t;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } ctl_state_t;

  function automatic logic [CLASS_W-1:0] class_of(input logic [CNT_W-1:0] n);
    logic [CLASS_W-1:0] c;
    if (n <= CNT_W'(2)) c = CLASS_1BPP;
    else if (n <= CNT_W'(4)) c = CLASS_2BPP;
    else if (n <= CNT_W'(16)) c = CLASS_4BPP;
    else if (n <= CNT_W'(PALETTE_LIMIT)) c = CLASS_8BPP;
    else c = CLASS_NO_PAL;
    return c;
  endfunction

endpackage

// ===== rtl/ipga_cell.sv =====
// One cell of the color table row: holds one entry, compares or claims it.
// Depends on ipga_pkg.
module ipga_cell
  import ipga_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] cell_idx,
  input  logic [CNT_W-1:0] count,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  output logic             store
);

  logic [KEY_W-1:0] entry;
  logic             occupied;
  logic             hit;
  tok_t             tok_next;

  // Entries fill in order, so the occupied cells are the prefix below count.
  assign occupied = cell_idx < count;
  assign hit      = tok_in.vld && occupied && (entry == tok_in.key);
  assign store    = tok_in.vld && !tok_in.found && (cell_idx == count);

  always_comb begin
    tok_next       = tok_in;
    tok_next.found = tok_in.found | hit | store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_next.vld;
    end
    tok_out.found <= tok_next.found;
    tok_out.last  <= tok_next.last;
    tok_out.key   <= tok_next.key;
    if (store) begin
      entry <= tok_in.key;
    end
  end

endmodule

// ===== rtl/ipga_chain.sv =====
// Row of TABLE_DEPTH cells; a word advances one cell per cycle.
// Depends on ipga_pkg and ipga_cell.
module ipga_chain
  import ipga_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] count,
  input  tok_t             head,
  output tok_t             tail,
  output logic             any_store
);

  tok_t                   link [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] stores;

  assign link[0] = head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ipga_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_idx (CNT_W'(i)),
      .count    (count),
      .tok_in   (link[i]),
      .tok_out  (link[i+1]),
      .store    (stores[i])
    );
  end

  assign tail      = link[TABLE_DEPTH];
  assign any_store = |stores;

endmodule

// ===== rtl/image_palette_gray_alpha_analyzer.sv =====
// RGBA8 image analyzer: transparency flag, grayscale flag, distinct color count and palette
// class. Depends on ipga_pkg and ipga_chain.
//
// Pixels of an image are taken one per cycle while in_stall is low. Each pixel's color walks
// a row of 257 table cells, one cell per cycle, and the result of an image is registered once
// its last pixel leaves the end of the row, so the walk sets the delay. While the last pixel
// drains, no pixel is accepted; the next image may start as soon as the result is loaded,
// even while that result still waits to be taken. The last pixel of an image is held off
// while a previous result is still waiting. The threshold register takes writes at any
// cycle (ready is always high) and should only be written while the block is idle.
module image_palette_gray_alpha_analyzer
  import ipga_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CH_W-1:0]    cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CH_W-1:0]    red,
  input  logic [CH_W-1:0]    green,
  input  logic [CH_W-1:0]    blue,
  input  logic [CH_W-1:0]    alpha,
  input  logic               last_pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_transparent,
  output logic               is_grayscale,
  output logic [CLASS_W-1:0] color_class,
  output logic [CNT_W-1:0]   distinct_count
);

  ctl_state_t       state, state_next;
  logic [CH_W-1:0]  gray_threshold;
  logic [CNT_W-1:0] entries_used;
  logic             seen_transparent;
  logic             still_gray;
  logic             in_accept;
  logic             out_take;
  logic             done;
  logic             not_gray;
  tok_t             head;
  tok_t             tail;
  logic             any_store;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign done      = tail.vld && tail.last;

  assign not_gray = (abs_diff(red, green) > gray_threshold) ||
                    (abs_diff(red, blue) > gray_threshold) ||
                    (abs_diff(green, blue) > gray_threshold);

  always_comb begin
    head.vld   = in_accept;
    head.found = 1'b0;
    head.last  = last_pixel;
    head.key   = {alpha, blue, green, red};
  end

  ipga_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .count     (entries_used),
    .head      (head),
    .tail      (tail),
    .any_store (any_store)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (in_accept && last_pixel) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Outputs of the state machine: hold the last pixel off while a result is pending.
  always_comb begin
    case (state)
      ST_RUN:   in_stall = last_pixel && out_valid;
      ST_DRAIN: in_stall = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_RUN;
      gray_threshold   <= '0;
      entries_used     <= '0;
      seen_transparent <= 1'b0;
      still_gray       <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        gray_threshold <= cfg_data;
      end
      if (done) begin
        // drop per-image state once the last word leaves the row
        entries_used     <= '0;
        seen_transparent <= 1'b0;
        still_gray       <= 1'b1;
      end else begin
        if (any_store) entries_used <= entries_used + CNT_W'(1);
        if (in_accept && (alpha != ALPHA_OPAQUE)) seen_transparent <= 1'b1;
        if (in_accept && not_gray) still_gray <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      is_transparent <= seen_transparent;
      is_grayscale   <= still_gray;
      color_class    <= class_of(entries_used);
      distinct_count <= entries_used;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= CNT_W'(TABLE_DEPTH))
    else $error("entry count past table depth");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    any_store |-> (entries_used < CNT_W'(TABLE_DEPTH)))
    else $error("store into a full table");

  a_drain_closed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> !in_accept)
    else $error("pixel accepted while draining");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> ((state == ST_DRAIN) && !out_valid))
    else $error("image end reached with no drain or a pending result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid)
    else $error("result not loaded after image end");

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for image_palette_gray_alpha_analyzer: random and directed RGBA images,
// predicted results checked word by word against the block's output.
// Depends on ipga_pkg and the analyzer RTL.
module testbench
  import ipga_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int LONG_HOLD      = 1500;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            last;
  } pixel_t;

  typedef struct packed {
    logic               transparent;
    logic               gray;
    logic [CLASS_W-1:0] cls;
    logic [CNT_W-1:0]   count;
  } image_summary_t;

  typedef enum int {
    PIX_NOISE,
    PIX_NEAR_GRAY,
    PIX_OPAQUE,
    PIX_EXTREME
  } pixel_flavor_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CH_W-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CH_W-1:0]    red = '0;
  logic [CH_W-1:0]    green = '0;
  logic [CH_W-1:0]    blue = '0;
  logic [CH_W-1:0]    alpha = '0;
  logic               last_pixel = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               is_transparent;
  logic               is_grayscale;
  logic [CLASS_W-1:0] color_class;
  logic [CNT_W-1:0]   distinct_count;

  image_palette_gray_alpha_analyzer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .last_pixel    (last_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_transparent(is_transparent),
    .is_grayscale  (is_grayscale),
    .color_class   (color_class),
    .distinct_count(distinct_count)
  );

  pixel_t         pixel_q[$];
  image_summary_t summary_q[$];
  pixel_t         on_wire;
  int unsigned    pixels_queued = 0;

  // per-image analysis state
  bit             color_seen[logic [31:0]];
  int unsigned    colors_held = 0;
  bit             any_clear = 1'b0;
  bit             all_gray = 1'b1;
  logic [CH_W-1:0] gray_limit = '0;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int             hold_requests = 0;
  int             holds_served = 0;
  int             hold_left = 0;
  int             fail_count = 0;
  int             quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned chan_gap(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic logic [CLASS_W-1:0] class_for_count(input int unsigned n);
    if (n <= 2) return CLASS_1BPP;
    if (n <= 4) return CLASS_2BPP;
    if (n <= 16) return CLASS_4BPP;
    if (n <= PALETTE_LIMIT) return CLASS_8BPP;
    return CLASS_NO_PAL;
  endfunction

  task automatic absorb_pixel(input pixel_t p);
    logic [31:0]    key;
    image_summary_t s;
    key = {p.alpha, p.blue, p.green, p.red};
    if (p.alpha != ALPHA_OPAQUE) any_clear = 1'b1;
    if (chan_gap(p.red, p.green) > gray_limit || chan_gap(p.red, p.blue) > gray_limit ||
        chan_gap(p.green, p.blue) > gray_limit) all_gray = 1'b0;
    // a full table takes no new colors
    if (!color_seen.exists(key) && colors_held < TABLE_DEPTH) begin
      color_seen[key] = 1'b1;
      colors_held++;
    end
    if (p.last) begin
      s.transparent = any_clear;
      s.gray        = all_gray;
      s.cls         = class_for_count(colors_held);
      s.count       = CNT_W'(colors_held);
      summary_q.push_back(s);
      color_seen.delete();
      colors_held = 0;
      any_clear   = 1'b0;
      all_gray    = 1'b1;
    end
  endtask

  task automatic check_summary();
    image_summary_t want;
    if (summary_q.size() == 0) begin
      $error("result word with no image pending: transparent %0d gray %0d class %0d count %0d",
             is_transparent, is_grayscale, color_class, distinct_count);
      fail_count++;
    end else begin
      want = summary_q.pop_front();
      if (is_transparent !== want.transparent) begin
        $error("is_transparent: expected %0d, got %0d", want.transparent, is_transparent);
        fail_count++;
      end
      if (is_grayscale !== want.gray) begin
        $error("is_grayscale: expected %0d, got %0d", want.gray, is_grayscale);
        fail_count++;
      end
      if (color_class !== want.cls) begin
        $error("color_class: expected %0d, got %0d", want.cls, color_class);
        fail_count++;
      end
      if (distinct_count !== want.count) begin
        $error("distinct_count: expected %0d, got %0d", want.count, distinct_count);
        fail_count++;
      end
    end
  endtask

  // Driver: advance to the next pixel only when the current word is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_pixel(on_wire);
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = pixel_q.pop_front();
          in_valid   <= 1'b1;
          red        <= on_wire.red;
          green      <= on_wire.green;
          blue       <= on_wire.blue;
          alpha      <= on_wire.alpha;
          last_pixel <= on_wire.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check taken result words, drive the stall pattern and long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_summary();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left    <= LONG_HOLD;
        out_stall    <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_pixel(input pixel_t p);
    pixel_q.push_back(p);
    pixels_queued++;
  endtask

  task automatic queue_rgba(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a, input logic last);
    pixel_t p;
    p = '{red: r, green: g, blue: b, alpha: a, last: last};
    queue_pixel(p);
  endtask

  function automatic logic [CH_W-1:0] extreme_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] near_level(input int v, input int spread);
    int x;
    x = v + int'($urandom_range(2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return CH_W'(x);
  endfunction

  function automatic pixel_t rand_pixel(input pixel_flavor_t flavor);
    pixel_t p;
    int     v;
    int     spread;
    p.last  = 1'b0;
    p.alpha = ($urandom_range(3) == 0) ? CH_W'($urandom) : ALPHA_OPAQUE;
    case (flavor)
      PIX_NEAR_GRAY: begin
        v      = $urandom_range(255);
        spread = $urandom_range(1) ? 0 : 3;
        p.red   = near_level(v, spread);
        p.green = near_level(v, spread);
        p.blue  = near_level(v, spread);
      end
      PIX_EXTREME: begin
        p.red   = extreme_level();
        p.green = extreme_level();
        p.blue  = extreme_level();
        p.alpha = extreme_level();
      end
      PIX_OPAQUE: begin
        p.red   = CH_W'($urandom);
        p.green = CH_W'($urandom);
        p.blue  = CH_W'($urandom);
        p.alpha = ALPHA_OPAQUE;
      end
      default: begin
        p.red   = CH_W'($urandom);
        p.green = CH_W'($urandom);
        p.blue  = CH_W'($urandom);
        p.alpha = CH_W'($urandom);
      end
    endcase
    return p;
  endfunction

  // Every palette color shows up at least once, then repeats, in shuffled order.
  task automatic queue_palette_image(input int unsigned n_colors, input int unsigned length,
                                     input pixel_flavor_t flavor);
    pixel_t      pal[$];
    pixel_t      img[$];
    pixel_t      tmp;
    int unsigned k;
    int unsigned j;
    for (k = 0; k < n_colors; k++) pal.push_back(rand_pixel(flavor));
    for (k = 0; k < length; k++)
      img.push_back(k < n_colors ? pal[k] : pal[$urandom_range(n_colors - 1)]);
    for (k = length - 1; k > 0; k--) begin
      j      = $urandom_range(k);
      tmp    = img[k];
      img[k] = img[j];
      img[j] = tmp;
    end
    for (k = 0; k < length; k++) begin
      tmp      = img[k];
      tmp.last = (k == length - 1);
      queue_pixel(tmp);
    end
  endtask

  // Many distinct colors followed by a few repeats; past 257 the table saturates.
  task automatic queue_wide_image(input int unsigned n_unique);
    bit          used[logic [31:0]];
    pixel_t      img[$];
    pixel_t      p;
    logic [31:0] key;
    int unsigned k;
    while (img.size() < n_unique) begin
      p   = rand_pixel(PIX_NOISE);
      key = {p.alpha, p.blue, p.green, p.red};
      if (!used.exists(key)) begin
        used[key] = 1'b1;
        img.push_back(p);
      end
    end
    repeat (4) img.push_back(img[$urandom_range(n_unique - 1)]);
    for (k = 0; k < img.size(); k++) begin
      p      = img[k];
      p.last = (k == img.size() - 1);
      queue_pixel(p);
    end
  endtask

  task automatic queue_random_image();
    int unsigned n;
    case ($urandom_range(7))
      0: n = 1;
      1: n = 2;
      2: n = 3;
      3: n = 4;
      4: n = 5;
      5: n = 16;
      6: n = 17;
      default: n = $urandom_range(1, 12);
    endcase
    queue_palette_image(n, n + $urandom_range(8), pixel_flavor_t'($urandom_range(3)));
  endtask

  task automatic fill_random(input int unsigned budget);
    int unsigned target;
    target = pixels_queued + budget;
    while (pixels_queued < target) queue_random_image();
  endtask

  task automatic write_threshold(input logic [CH_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    gray_limit = v;
    @(negedge clk);
  endtask

  task automatic wait_results();
    while (pixel_q.size() != 0 || in_valid || summary_q.size() != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic start_phase(input logic [CH_W-1:0] threshold, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    write_threshold(threshold);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero threshold: any channel difference breaks gray
    start_phase(8'd0, 0, 0);
    queue_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    queue_rgba(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
    queue_rgba(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    queue_rgba(8'd0, 8'd255, 8'd0, 8'd254, 1'b0);
    queue_rgba(8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
    queue_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_rgba(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
    queue_rgba(8'd1, 8'd0, 8'd0, 8'd255, 1'b1);
    queue_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    queue_rgba(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    queue_rgba(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    queue_rgba(8'd128, 8'd128, 8'd128, 8'd255, 1'b0);
    queue_rgba(8'd128, 8'd128, 8'd128, 8'd255, 1'b1);
    for (int k = 1; k <= 5; k++) queue_rgba(8'(10 * k), 8'(10 * k), 8'(10 * k), 8'd255, k == 5);
    queue_wide_image(260);
    fill_random(80);
    // hold the sender until every result is back
    wait_results();
    fill_random(80);
    wait_idle();

    // full-scale threshold: nothing can break gray
    start_phase(8'd255, 67, 0);
    queue_rgba(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
    queue_rgba(8'd255, 8'd0, 8'd255, 8'd255, 1'b1);
    fill_random(160);
    wait_idle();

    start_phase(8'd254, 0, 67);
    queue_rgba(8'd0, 8'd255, 8'd128, 8'd255, 1'b1);
    queue_rgba(8'd1, 8'd255, 8'd128, 8'd255, 1'b1);
    queue_wide_image(256);
    // long receiver hold while pixels keep coming, so the input backs up
    hold_requests++;
    fill_random(160);
    wait_idle();

    start_phase(8'd1, 12, 12);
    fill_random(160);
    wait_idle();

    start_phase(CH_W'($urandom_range(2, 253)), 0, 0);
    fill_random(160);
    wait_idle();

    if (fail_count == 0 && summary_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ipga_pkg.sv
rtl/ipga_cell.sv
rtl/ipga_chain.sv
rtl/image_palette_gray_alpha_analyzer.sv
tb/testbench.sv
